// ===== hw/rtl/tte_pkg.sv =====
// Shared types and constants for the TLV tag extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

   // width of the saturating payload byte counter
   localparam int TotalWidth = 16;

   // queue between the parser and the result sequencer
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   // result kinds
   localparam logic KindPayload = 1'b0;
   localparam logic KindSummary = 1'b1;

   // one queue entry: the results caused by one input word
   typedef struct packed {
      logic        has_payload;
      logic [7:0]  payload_byte;
      logic        has_summary;
      logic [63:0] uint_value;
      logic        uint_ok;
      logic [7:0]  first_length;
      logic        found;
      logic [15:0] payload_total;
   } tte_entry_type;

   // parser to queue write side
   typedef struct packed {
      logic          push;
      tte_entry_type entry;
   } tte_push_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tte_front.sv =====
// Parser front end: accepts buffer words, tracks TLV parse state and
// builds queue entries. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_front
   import tte_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_byte_in,
   input  wire logic         req_last_byte,
   input  wire logic         queue_full,
   output tte_push_type      push_out
);

   typedef enum logic [1:0] {
      PH_TAG = 2'd0,
      PH_LEN = 2'd1,
      PH_VAL = 2'd2
   } phase_type;

   localparam logic [TotalWidth-1:0] TotalLimit = {TotalWidth{1'b1}};

   logic [7:0]            wanted_tag_ff;
   phase_type             phase_ff, phase_in;
   logic                  entry_matches_ff, entry_matches_in;
   logic [7:0]            bytes_left_ff, bytes_left_in;
   logic                  in_first_ff, in_first_in;
   logic                  first_seen_ff, first_seen_in;
   logic [7:0]            first_len_ff, first_len_in;
   logic [63:0]           value_accum_ff, value_accum_in;
   logic [TotalWidth-1:0] total_count_ff, total_count_in;
   logic [1:0]            buffer_count_ff, buffer_count_in;

   logic                  accept;
   logic [7:0]            byte_idx;
   logic                  short_buf;
   logic                  complete;
   logic                  len_ok;
   logic                  uint_ok;
   tte_entry_type         entry;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign short_buf = (buffer_count_ff == 2'd0);
   assign byte_idx  = first_len_ff - bytes_left_ff;

   // parse state update for one word
   always_comb begin
      phase_in         = phase_ff;
      entry_matches_in = entry_matches_ff;
      bytes_left_in    = bytes_left_ff;
      in_first_in      = in_first_ff;
      first_seen_in    = first_seen_ff;
      first_len_in     = first_len_ff;
      value_accum_in   = value_accum_ff;
      total_count_in   = total_count_ff;
      buffer_count_in  = (buffer_count_ff < 2'd2) ? buffer_count_ff + 2'd1 : buffer_count_ff;
      entry            = '0;
      case (phase_ff)
         PH_LEN: begin
            bytes_left_in = req_byte_in;
            if (in_first_ff) begin
               first_len_in   = req_byte_in;
               value_accum_in = '0;
               if (req_byte_in == 8'd0) begin
                  in_first_in = 1'b0;
               end
            end
            phase_in = (req_byte_in != 8'd0) ? PH_VAL : PH_TAG;
         end
         PH_VAL: begin
            if (entry_matches_ff) begin
               entry.has_payload  = 1'b1;
               entry.payload_byte = req_byte_in;
               if (total_count_ff < TotalLimit) begin
                  total_count_in = total_count_ff + 1'b1;
               end
            end
            if (in_first_ff && (byte_idx < 8'd8)) begin
               value_accum_in = value_accum_ff
                  | (64'(req_byte_in) << {byte_idx[2:0], 3'b000});
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_in == 8'd0) begin
               phase_in    = PH_TAG;
               in_first_in = 1'b0;
            end
         end
         default: begin
            // tag word, also taken for the unused phase code
            entry_matches_in = (req_byte_in == wanted_tag_ff);
            if (entry_matches_in && !first_seen_ff) begin
               first_seen_in  = 1'b1;
               in_first_in    = 1'b1;
               first_len_in   = '0;
               value_accum_in = '0;
            end
            phase_in = PH_LEN;
         end
      endcase

      // end-of-buffer summary from the updated state
      complete = first_seen_in && !in_first_in;
      len_ok   = (first_len_in == 8'd1) || (first_len_in == 8'd2)
              || (first_len_in == 8'd4) || (first_len_in == 8'd8);
      uint_ok  = complete && len_ok;
      if (req_last_byte) begin
         entry.has_summary = 1'b1;
         if (!short_buf) begin
            entry.uint_value    = uint_ok ? value_accum_in : 64'd0;
            entry.uint_ok       = uint_ok;
            entry.first_length  = first_seen_in ? first_len_in : 8'd0;
            entry.found         = first_seen_in;
            entry.payload_total = 16'(total_count_in);
         end
      end
   end

   assign push_out.push  = accept && (entry.has_payload || entry.has_summary);
   assign push_out.entry = entry;

   // state registers; per-buffer state clears after the final word
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_tag_ff    <= '0;
         phase_ff         <= PH_TAG;
         entry_matches_ff <= 1'b0;
         bytes_left_ff    <= '0;
         in_first_ff      <= 1'b0;
         first_seen_ff    <= 1'b0;
         first_len_ff     <= '0;
         value_accum_ff   <= '0;
         total_count_ff   <= '0;
         buffer_count_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            wanted_tag_ff <= csr_wr_data;
         end
         if (accept) begin
            if (req_last_byte) begin
               phase_ff         <= PH_TAG;
               entry_matches_ff <= 1'b0;
               bytes_left_ff    <= '0;
               in_first_ff      <= 1'b0;
               first_seen_ff    <= 1'b0;
               first_len_ff     <= '0;
               value_accum_ff   <= '0;
               total_count_ff   <= '0;
               buffer_count_ff  <= '0;
            end else begin
               phase_ff         <= phase_in;
               entry_matches_ff <= entry_matches_in;
               bytes_left_ff    <= bytes_left_in;
               in_first_ff      <= in_first_in;
               first_seen_ff    <= first_seen_in;
               first_len_ff     <= first_len_in;
               value_accum_ff   <= value_accum_in;
               total_count_ff   <= total_count_in;
               buffer_count_ff  <= buffer_count_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tte_queue.sv =====
// Short queue of result entries between parser and sequencer.
// Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_queue
   import tte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tte_push_type  push_in,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output tte_entry_type      head
);

   localparam logic [QueuePtrWidth:0] DepthCount = (QueuePtrWidth + 1)'(QueueDepth);

   tte_entry_type            mem [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = (count_ff == DepthCount);
   assign empty   = (count_ff == '0);
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_in.entry;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tte_back.sv =====
// Result sequencer: takes queue entries and emits payload and summary
// words through a registered output stage. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_back
   import tte_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           empty,
   input  wire tte_entry_type  head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic                rsp_result_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic [63:0]         rsp_uint_value,
   output logic                rsp_uint_ok,
   output logic [7:0]          rsp_first_length,
   output logic                rsp_found,
   output logic [15:0]         rsp_payload_total,
   output logic                rsp_last
);

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [63:0] uint_value;
      logic        uint_ok;
      logic [7:0]  first_length;
      logic        found;
      logic [15:0] payload_total;
      logic        last;
   } rsp_type;

   logic          valid_ff, valid_in;
   logic          pend_ff, pend_in;
   tte_entry_type hold_ff, hold_in;
   rsp_type       rsp_ff, rsp_in;
   logic          load;

   function automatic rsp_type summary_word(tte_entry_type e);
      rsp_type r;
      r               = '0;
      r.result_kind   = KindSummary;
      r.uint_value    = e.uint_value;
      r.uint_ok       = e.uint_ok;
      r.first_length  = e.first_length;
      r.found         = e.found;
      r.payload_total = e.payload_total;
      r.last          = 1'b1;
      return r;
   endfunction

   assign load = !valid_ff || rsp_ready;

   // pick the next word: a held summary first, then the queue head
   always_comb begin
      pop      = 1'b0;
      valid_in = valid_ff;
      pend_in  = pend_ff;
      hold_in  = hold_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            rsp_in   = summary_word(hold_ff);
         end else if (!empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head.has_payload) begin
               rsp_in              = '0;
               rsp_in.result_kind  = KindPayload;
               rsp_in.payload_byte = head.payload_byte;
               rsp_in.last         = !head.has_summary;
               pend_in             = head.has_summary;
               hold_in             = head;
            end else begin
               rsp_in = summary_word(head);
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = rsp_ff.result_kind;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_uint_value    = rsp_ff.uint_value;
   assign rsp_uint_ok       = rsp_ff.uint_ok;
   assign rsp_first_length  = rsp_ff.first_length;
   assign rsp_found         = rsp_ff.found;
   assign rsp_payload_total = rsp_ff.payload_total;
   assign rsp_last          = rsp_ff.last;

endmodule

`default_nettype wire

// ===== hw/rtl/tlv_tag_extractor_top.sv =====
// TLV tag extractor: scans a TLV8 buffer one byte per word and returns the
// value bytes of entries carrying the configured tag, plus a per-buffer
// summary on the final byte.
//
// Channels: req_* carries one buffer byte per word (req_last_byte marks the
// final byte); rsp_* carries results, either a payload byte (kind 0) or the
// end-of-buffer summary (kind 1); rsp_last marks the final word that one
// input byte caused. csr_wr_en / csr_wr_data write wanted_tag; the user must
// write it only while idle, which the block does not enforce. A result
// passes the queue, then the registered output stage; a summary that
// follows a payload word of the same byte is held and sent as the next word.
// Throughput: one byte per cycle while the queue is not full; a final byte
// with a payload byte takes two output words, absorbed by the four-entry queue.
// Reset (synchronous, active high) clears the parse state, the queue, the
// output stage and wanted_tag. When the receiver stalls, the output word
// holds, the queue fills, and req_ready drops once it is full.
// Depends on tte_pkg, tte_front, tte_queue, tte_back.
`timescale 1ns / 1ps
`default_nettype none

module tlv_tag_extractor_top
   import tte_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_byte_in,
   input  wire logic         req_last_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_payload_byte,
   output logic [63:0]       rsp_uint_value,
   output logic              rsp_uint_ok,
   output logic [7:0]        rsp_first_length,
   output logic              rsp_found,
   output logic [15:0]       rsp_payload_total,
   output logic              rsp_last
);

   tte_push_type  push;
   tte_entry_type head;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;

   // parser
   tte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push_out      (push)
   );

   // decoupling queue
   tte_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head    (head)
   );

   // result sequencer
   tte_back u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (queue_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_uint_value    (rsp_uint_value),
      .rsp_uint_ok       (rsp_uint_ok),
      .rsp_first_length  (rsp_first_length),
      .rsp_found         (rsp_found),
      .rsp_payload_total (rsp_payload_total),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire
